### sv/weighted_union_find_assert.svh
// assertion macros for the weighted union-find block
`ifndef WEIGHTED_UNION_FIND_ASSERT_SVH
`define WEIGHTED_UNION_FIND_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define WUF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define WUF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/wuf_pkg.sv
// package: constants and types for the weighted union-find block
`timescale 1ns / 1ps
package wuf_pkg;
	localparam int NODES_DEF       = 1024;
	localparam int WEIGHT_BITS_DEF = 32;
	localparam int NODE_W          = 10;
	localparam int DELTA_W         = 32;
	localparam int SIZE_W          = 11;
	localparam int RED_CNT_W       = 4;

	typedef enum logic [0:0] {ALU_ADD, ALU_SUB} alu_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RED, ST_F1_RD, ST_F1_CHK, ST_F2_RD, ST_F2_CHK,
		ST_EVAL, ST_EVAL2, ST_LINK1, ST_LINK2, ST_OUT
	} state_t;
endpackage

### sv/wuf_in_if.sv
// input channel interface: one word per operation
`timescale 1ns / 1ps
interface wuf_in_if import wuf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [NODE_W-1:0]  node_a;
	logic [NODE_W-1:0]  node_b;
	logic signed [DELTA_W-1:0] weight_delta;

	modport source (output valid, op, node_a, node_b, weight_delta, input ready);
	modport sink   (input valid, op, node_a, node_b, weight_delta, output ready);
endinterface

### sv/wuf_out_if.sv
// output channel interface: one result word per operation
`timescale 1ns / 1ps
interface wuf_out_if import wuf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               merged;
	logic               were_connected;
	logic signed [DELTA_W-1:0] offset;
	logic [SIZE_W-1:0]  set_size;

	modport source (output valid, merged, were_connected, offset, set_size, input ready);
	modport sink   (input valid, merged, were_connected, offset, set_size, output ready);
endinterface

### sv/wuf_alu.sv
// shared potential adder/subtractor
`timescale 1ns / 1ps
module wuf_alu import wuf_pkg::*; #(
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  alu_op_t               op,
	input  logic [WEIGHT_BITS-1:0] x,
	input  logic [WEIGHT_BITS-1:0] y,
	output logic [WEIGHT_BITS-1:0] res
);
	// wrapping add or subtract
	always_comb begin
		unique case (op)
			ALU_ADD: res = x + y;
			ALU_SUB: res = x - y;
			default: res = x + y;
		endcase
	end
endmodule

### sv/wuf_store.sv
// link/size and potential tables, one write and one registered read port
`timescale 1ns / 1ps
module wuf_store import wuf_pkg::*; #(
	parameter int NODES       = NODES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	parameter int IDX_W       = 10,
	parameter int LINK_W      = 12
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [IDX_W-1:0]       waddr,
	input  logic [LINK_W-1:0]      wlink,
	input  logic [WEIGHT_BITS-1:0] wpot,
	input  logic [IDX_W-1:0]       raddr,
	output logic [LINK_W-1:0]      rlink,
	output logic [WEIGHT_BITS-1:0] rpot
);
	logic [LINK_W-1:0]      link_mem [NODES];
	logic [WEIGHT_BITS-1:0] pot_mem  [NODES];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			link_mem[waddr] <= wlink;
			pot_mem[waddr]  <= wpot;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rlink <= link_mem[raddr];
		rpot  <= pot_mem[raddr];
	end
endmodule

### sv/weighted_union_find.sv
// weighted union-find top level: sequencer, datapath and table
// Sequence: the accept cycle, index reduction, then for each node a find that walks to the root
// and then links every node on its chain straight to the root; an evaluate step, a second evaluate
// step and two link writes on a merge, and the result word presented until it is taken.
// Throughput: one operation at a time; the single
// table read port and the shared adder set the pace.
// Reset: asynchronous; then a clearing pass over the NODES entries makes every node a singleton
`timescale 1ns / 1ps
module weighted_union_find import wuf_pkg::*; #(
	parameter int NODES       = NODES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wuf_in_if.sink    in_w,
	wuf_out_if.source out_w
);
	`include "weighted_union_find_assert.svh"

	localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int SZ_W   = $clog2(NODES + 1);
	localparam int VAL_W  = (IDX_W > SZ_W) ? IDX_W : SZ_W;
	localparam int LINK_W = VAL_W + 1;
	localparam int RED_K  = (NODES >= 1024) ? 0 : $clog2(1024 / NODES);
	localparam int W      = WEIGHT_BITS;

	state_t state_q, state_d;

	logic                 op_q, which_q, swap_q, conn_q, merged_q;
	logic [NODE_W-1:0]    a_q, b_q, a_red, b_red;
	logic [RED_CNT_W-1:0] red_q;
	logic [W-1:0]         w_q, sum_q, r_q, pa_q, pb_q, tmp_q, d_q, off_q;
	logic [IDX_W-1:0]     cur_q, root_q, ra_q, rb_q, clr_q, a_idx, b_idx, big, small_n;
	logic [SZ_W-1:0]      size_q, sa_q, sb_q, gsize_q;
	logic [31:0]          shifted_n, a32, b32, gs32;
	logic signed [63:0]   w64, off64;
	logic signed [W-1:0]  off_s;

	logic                 we;
	logic [IDX_W-1:0]     waddr, raddr;
	logic [LINK_W-1:0]    wlink, rlink;
	logic [W-1:0]         wpot, rpot;
	alu_op_t              alu_op;
	logic [W-1:0]         alu_x, alu_y, alu_res;

	wuf_store #(
		.NODES(NODES), .WEIGHT_BITS(W), .IDX_W(IDX_W), .LINK_W(LINK_W)
	) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wlink(wlink), .wpot(wpot),
		.raddr(raddr), .rlink(rlink), .rpot(rpot)
	);

	wuf_alu #(.WEIGHT_BITS(W)) u_alu (
		.op(alu_op), .x(alu_x), .y(alu_y), .res(alu_res)
	);

	// index reduction modulo the table size, one compare-subtract per cycle
	always_comb begin
		shifted_n = 32'(NODES) << red_q;
		a32       = 32'(a_q);
		b32       = 32'(b_q);
		a_red     = (a32 >= shifted_n) ? NODE_W'(a32 - shifted_n) : a_q;
		b_red     = (b32 >= shifted_n) ? NODE_W'(b32 - shifted_n) : b_q;
		a_idx     = IDX_W'(32'(a_q));
		b_idx     = IDX_W'(32'(b_q));
	end

	// link roles for a merge
	assign big     = swap_q ? rb_q : ra_q;
	assign small_n = swap_q ? ra_q : rb_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state, table and adder control
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = cur_q;
		wlink   = '0;
		wpot    = '0;
		raddr   = cur_q;
		alu_op  = ALU_ADD;
		alu_x   = sum_q;
		alu_y   = rpot;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wlink = {1'b1, VAL_W'(1)};
				if (32'(clr_q) == 32'(NODES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_w.valid) state_d = ST_RED;
			end
			ST_RED: begin
				if (red_q == '0) state_d = ST_F1_RD;
			end
			ST_F1_RD: begin
				state_d = ST_F1_CHK;
			end
			ST_F1_CHK: begin
				if (rlink[LINK_W-1]) state_d = ST_F2_RD;
				else state_d = ST_F1_RD;
			end
			ST_F2_RD: begin
				if (cur_q == root_q) state_d = which_q ? ST_EVAL : ST_F1_RD;
				else state_d = ST_F2_CHK;
			end
			ST_F2_CHK: begin
				we     = 1'b1;
				wlink  = {1'b0, VAL_W'(root_q)};
				wpot   = r_q;
				alu_op = ALU_SUB;
				alu_x  = r_q;
				state_d = ST_F2_RD;
			end
			ST_EVAL: begin
				if (ra_q == rb_q) begin
					alu_op  = ALU_SUB;
					alu_x   = pb_q;
					alu_y   = pa_q;
					state_d = ST_OUT;
				end else if (op_q) begin
					alu_x   = w_q;
					alu_y   = pa_q;
					state_d = ST_EVAL2;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_EVAL2: begin
				alu_op  = ALU_SUB;
				alu_x   = tmp_q;
				alu_y   = pb_q;
				state_d = ST_LINK1;
			end
			ST_LINK1: begin
				we      = 1'b1;
				waddr   = big;
				wlink   = {1'b1, VAL_W'(gsize_q)};
				alu_op  = ALU_SUB;
				alu_x   = '0;
				alu_y   = d_q;
				state_d = ST_LINK2;
			end
			ST_LINK2: begin
				we      = 1'b1;
				waddr   = small_n;
				wlink   = {1'b0, VAL_W'(big)};
				wpot    = d_q;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_w.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q  <= in_w.op;
				a_q   <= in_w.node_a;
				b_q   <= in_w.node_b;
				w_q   <= w64[W-1:0];
				red_q <= RED_CNT_W'(RED_K);
			end
			ST_RED: begin
				a_q     <= a_red;
				b_q     <= b_red;
				red_q   <= red_q - 1'b1;
				cur_q   <= IDX_W'(32'(a_red));
				sum_q   <= '0;
				which_q <= 1'b0;
			end
			ST_F1_CHK: begin
				if (rlink[LINK_W-1]) begin
					root_q <= cur_q;
					size_q <= SZ_W'(rlink[VAL_W-1:0]);
					r_q    <= sum_q;
					cur_q  <= which_q ? b_idx : a_idx;
				end else begin
					sum_q <= alu_res;
					cur_q <= IDX_W'(rlink[VAL_W-1:0]);
				end
			end
			ST_F2_RD: begin
				if (cur_q == root_q) begin
					if (!which_q) begin
						ra_q    <= root_q;
						pa_q    <= sum_q;
						sa_q    <= size_q;
						which_q <= 1'b1;
						cur_q   <= b_idx;
						sum_q   <= '0;
					end else begin
						rb_q <= root_q;
						pb_q <= sum_q;
						sb_q <= size_q;
					end
				end
			end
			ST_F2_CHK: begin
				r_q   <= alu_res;
				cur_q <= IDX_W'(rlink[VAL_W-1:0]);
			end
			ST_EVAL: begin
				conn_q   <= (ra_q == rb_q);
				merged_q <= 1'b0;
				gsize_q  <= sa_q;
				tmp_q    <= alu_res;
				off_q    <= (ra_q == rb_q) ? alu_res : '0;
			end
			ST_EVAL2: begin
				d_q      <= alu_res;
				off_q    <= w_q;
				gsize_q  <= sa_q + sb_q;
				merged_q <= 1'b1;
				swap_q   <= (sa_q < sb_q);
			end
			ST_LINK1: begin
				if (swap_q) d_q <= alu_res;
			end
			default: begin
			end
		endcase
	end

	// weight and offset width conversion
	always_comb begin
		w64   = 64'(in_w.weight_delta);
		off_s = off_q;
		off64 = 64'(off_s);
		gs32  = 32'(gsize_q);
	end

	// handshake and result word
	assign in_w.ready           = (state_q == ST_IDLE);
	assign out_w.valid          = (state_q == ST_OUT);
	assign out_w.merged         = merged_q;
	assign out_w.were_connected = conn_q;
	assign out_w.offset         = off64[31:0];
	assign out_w.set_size       = gs32[SIZE_W-1:0];

	// checks on the sequencer
	`WUF_ASSERT_SAME(a_no_overlap, out_w.valid, !in_w.ready, "input ready while result pending")
	`WUF_ASSERT_SAME(a_merge_disjoint, out_w.valid && out_w.merged, !out_w.were_connected,
		"merge reported on connected nodes")
	`WUF_ASSERT_NEXT(a_accept_reduce, in_w.valid && in_w.ready, state_q == ST_RED,
		"accepted word did not start reduction")
	`WUF_ASSERT_SAME(a_clear_blocks, state_q == ST_CLEAR, !in_w.ready && !out_w.valid,
		"handshake active during clearing")
endmodule

### dv/testbench.sv
// testbench for the weighted union-find block: directed and random operations checked against a software table
`timescale 1ns / 1ps
module testbench import wuf_pkg::*; ();
	localparam int N = NODES_DEF;
	localparam int LIMIT = 2_000_000;

	typedef struct packed {
		logic              op;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [31:0]       weight_delta;
	} op_word_t;

	typedef struct packed {
		logic        merged;
		logic        were_connected;
		logic [31:0] offset;
		logic [SIZE_W-1:0] set_size;
	} res_word_t;

	logic clk;
	logic arst_n;
	wuf_in_if  in_w ();
	wuf_out_if out_w ();

	weighted_union_find uut (.clk(clk), .arst_n(arst_n), .in_w(in_w), .out_w(out_w));

	op_word_t  pending_ops[$];
	res_word_t expected_res[$];
	int        parent_or_size[N];
	logic [31:0] pot[N];
	int        fail_count;
	int        cycle_count;
	int        hold_off;
	bit        stimulus_done;
	bit        calm;

	// locate root, compressing the chain and rebasing potentials onto the root
	function automatic int root_of(int x);
		int chain[$];
		int cur;
		int r;
		cur = x;
		while (parent_or_size[cur] >= 0) begin
			chain = {chain, cur};
			cur = parent_or_size[cur];
		end
		r = cur;
		for (int i = chain.size() - 1; i >= 0; i--) begin
			if (i < chain.size() - 1)
				pot[chain[i]] = pot[chain[i]] + pot[chain[i+1]];
			parent_or_size[chain[i]] = r;
		end
		return r;
	endfunction

	// predicted result for one operation, updating the shadow table
	function automatic res_word_t apply_op(op_word_t w);
		res_word_t r;
		int ra, rb, t;
		logic [31:0] d;
		ra = root_of(w.node_a);
		rb = root_of(w.node_b);
		r = '0;
		r.were_connected = (ra == rb);
		if (w.op && ra != rb) begin
			d = w.weight_delta + pot[w.node_a] - pot[w.node_b];
			if (-parent_or_size[ra] < -parent_or_size[rb]) begin
				t = ra; ra = rb; rb = t;
				d = -d;
			end
			parent_or_size[ra] += parent_or_size[rb];
			parent_or_size[rb] = ra;
			pot[rb] = d;
			r.merged = 1'b1;
		end
		ra = root_of(w.node_a);
		rb = root_of(w.node_b);
		if (ra == rb)
			r.offset = pot[w.node_b] - pot[w.node_a];
		r.set_size = SIZE_W'(-parent_or_size[ra]);
		return r;
	endfunction

	function automatic op_word_t mk(logic op, int a, int b, logic [31:0] wd);
		op_word_t w;
		w.op = op;
		w.node_a = a[NODE_W-1:0];
		w.node_b = b[NODE_W-1:0];
		w.weight_delta = wd;
		return w;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stimulus: directed cases, then mostly clustered random words
	initial begin
		int base;
		for (int i = 0; i < N; i++) begin
			parent_or_size[i] = -1;
			pot[i] = '0;
		end
		pending_ops = {pending_ops, mk(1'b0, 0, 1023, 32'h0)};
		pending_ops = {pending_ops, mk(1'b0, 5, 5, 32'h0)};
		pending_ops = {pending_ops, mk(1'b1, 0, 1023, 32'h7fff_ffff)};
		pending_ops = {pending_ops, mk(1'b1, 1023, 0, 32'h8000_0000)};
		pending_ops = {pending_ops, mk(1'b1, 1, 2, 32'hffff_ffff)};
		pending_ops = {pending_ops, mk(1'b1, 3, 1, 32'h1)};
		pending_ops = {pending_ops, mk(1'b1, 1, 0, 32'h5555_aaaa)};
		pending_ops = {pending_ops, mk(1'b0, 2, 1023, 32'h0)};
		pending_ops = {pending_ops, mk(1'b1, 2, 1023, 32'h1234_5678)};
		pending_ops = {pending_ops, mk(1'b0, 3, 1023, 32'h0)};
		pending_ops = {pending_ops, mk(1'b1, 7, 7, 32'h8000_0000)};
		pending_ops = {pending_ops, mk(1'b0, 1023, 3, 32'hffff_ffff)};
		for (int i = 0; i < 2000; i++) begin
			// narrow windows keep chains deep, the occasional wide pick is noise
			if (i % 400 == 0)
				base = $urandom_range(0, N - 64);
			if ($urandom_range(0, 9) == 0)
				pending_ops = {pending_ops, mk($urandom_range(0, 1), $urandom_range(0, N-1),
					$urandom_range(0, N-1), $urandom())};
			else
				pending_ops = {pending_ops, mk($urandom_range(0, 2) != 0,
					base + $urandom_range(0, 63), base + $urandom_range(0, 63), $urandom())};
		end
	end

	// reset
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: offers words from the queue with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_w.valid <= 1'b0;
			in_w.op <= 1'b0;
			in_w.node_a <= '0;
			in_w.node_b <= '0;
			in_w.weight_delta <= '0;
			stimulus_done <= 1'b0;
		end else begin
			if (in_w.valid && in_w.ready)
				void'(pending_ops.pop_front());
			if (in_w.valid && !in_w.ready) begin
				// hold the offered word
			end else if (pending_ops.size() > 0
					&& (calm || $urandom_range(0, 99) >= 21)) begin
				op_word_t w;
				w = pending_ops[0];
				in_w.valid <= 1'b1;
				in_w.op <= w.op;
				in_w.node_a <= w.node_a;
				in_w.node_b <= w.node_b;
				in_w.weight_delta <= w.weight_delta;
			end else begin
				in_w.valid <= 1'b0;
				if (pending_ops.size() == 0)
					stimulus_done <= 1'b1;
			end
		end
	end

	// predict on every accepted word
	always @(posedge clk) begin
		if (arst_n && in_w.valid && in_w.ready)
			expected_res = {expected_res, apply_op(mk(in_w.op, in_w.node_a, in_w.node_b,
				in_w.weight_delta))};
	end

	// receiver back-pressure: a long hold-off early, a calm stretch, else random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_w.ready <= 1'b0;
			hold_off <= 0;
			calm <= 1'b0;
		end else begin
			hold_off <= hold_off + 1;
			calm <= (hold_off >= 8000 && hold_off < 12000);
			if (hold_off >= 1100 && hold_off < 1700)
				out_w.ready <= 1'b0;
			else
				out_w.ready <= calm || ($urandom_range(0, 99) >= 21);
		end
	end

	// monitor: compare each result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_w.valid && out_w.ready) begin
			if (expected_res.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				res_word_t e;
				e = expected_res.pop_front();
				if (out_w.merged !== e.merged) begin
					$error("merged exp %0d got %0d", e.merged, out_w.merged);
					fail_count++;
				end
				if (out_w.were_connected !== e.were_connected) begin
					$error("were_connected exp %0d got %0d", e.were_connected,
						out_w.were_connected);
					fail_count++;
				end
				if (out_w.offset !== e.offset) begin
					$error("offset exp %0h got %0h", e.offset, out_w.offset);
					fail_count++;
				end
				if (out_w.set_size !== e.set_size) begin
					$error("set_size exp %0d got %0d", e.set_size, out_w.set_size);
					fail_count++;
				end
			end
		end
	end

	// end of run and timeout
	initial begin
		fail_count = 0;
		cycle_count = 0;
		@(posedge arst_n);
		while (!(stimulus_done && expected_res.size() == 0) && cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			repeat (200) @(posedge clk);
			if (fail_count == 0 && expected_res.size() == 0)
				$display("TEST PASSED");
			else
				$display("TEST FAILED");
			$finish;
		end
	end
endmodule
